// File: rtl/cap_pkg.sv
`default_nettype none
package cap_pkg;

	// field widths
	localparam int GAIN_W   = 16;
	localparam int GAIN_FRAC = 8;
	localparam int TARGET_W = 24;
	localparam int MEAS_W   = 16;
	localparam int DRIVE_W  = 32;

	// loop state widths
	localparam int ERR_W  = 25;
	localparam int SUM_W  = 40;
	localparam int DERR_W = ERR_W + 1;

	// accumulator for kp*e + ki*sum + kd*de
	localparam int ACC_W = SUM_W + GAIN_W + 2;
	localparam int RND_W = ACC_W - GAIN_FRAC;

	localparam int CNT_W = $clog2(GAIN_W);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_P = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_I = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_D = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_P = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_I = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_D = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_SUM,
		ST_MAC,
		ST_POST,
		ST_OUT
	} cap_state_t;

endpackage
`default_nettype wire

// File: rtl/cap_sample_if.sv
`default_nettype none
interface cap_sample_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [cap_pkg::TARGET_W-1:0] angle_target;
	logic signed [cap_pkg::MEAS_W-1:0]   angle_measured;
	logic signed [cap_pkg::TARGET_W-1:0] speed_target;
	logic signed [cap_pkg::MEAS_W-1:0]   speed_measured;

	modport source (
		output valid, action, angle_target, angle_measured, speed_target, speed_measured,
		input  ready
	);
	modport sink (
		input  valid, action, angle_target, angle_measured, speed_target, speed_measured,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/cap_result_if.sv
`default_nettype none
interface cap_result_if;
	logic valid;
	logic ready;
	logic signed [cap_pkg::DRIVE_W-1:0] drive;
	logic saturated;

	modport source (
		output valid, drive, saturated,
		input  ready
	);
	modport sink (
		input  valid, drive, saturated,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/cascaded_angle_speed_pid.sv
`default_nettype none
// Cascaded angle/speed positional PID. Each accepted sample item yields exactly one
// result item. Action 0 runs the speed loop against speed_target; action 1 runs the
// angle loop first and feeds its output (clamped to 24 bits) in as the speed setpoint.
// Each loop computes e = target - (measured << FRACTION_BITS), clamps it to 25 bits,
// adds it to a 40-bit saturating error sum, and outputs
// (kp*e + ki*sum + kd*(e - e_last) + 128) >>> 8 with Q8.8 gains. drive is clamped to
// 32 bits; saturated reports any clamp taken while handling the item.
// Sequencing: the three products of a loop are formed by one bit-serial MAC that takes
// one gain bit per cycle. Each loop steps through the sequencer states error, sum, MAC
// and post; a cascade item runs the angle loop and then the speed loop. A new item is
// taken once the previous one has been moved to the output register, which holds
// it until taken, so the block never works on two items at once. Gains are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. Indexes beyond the six gain registers
// are ignored.
module cascaded_angle_speed_pid #(
	parameter int FRACTION_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cap_sample_if.sink   sample,
	cap_result_if.source result,
	input  wire logic cfg_we,
	input  wire logic [cap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cap_pkg::GAIN_W-1:0]    cfg_data
);

	// error difference width: wide enough for target and scaled measurement
	localparam int SCALED_W = cap_pkg::MEAS_W + FRACTION_BITS;
	localparam int DIFF_W   = ((SCALED_W > cap_pkg::TARGET_W) ? SCALED_W
	                           : cap_pkg::TARGET_W) + 1;

	// gain registers
	logic signed [cap_pkg::GAIN_W-1:0] angle_p_q, angle_i_q, angle_d_q;
	logic signed [cap_pkg::GAIN_W-1:0] speed_p_q, speed_i_q, speed_d_q;

	// loop state
	logic signed [cap_pkg::SUM_W-1:0] angle_sum_q, speed_sum_q;
	logic signed [cap_pkg::ERR_W-1:0] angle_last_q, speed_last_q;

	// captured item
	logic action_q;
	logic signed [cap_pkg::TARGET_W-1:0] angle_target_q, speed_target_q;
	logic signed [cap_pkg::MEAS_W-1:0]   angle_meas_q, speed_meas_q;

	// working registers
	cap_pkg::cap_state_t state_q, state_d;
	logic loop_q;   // 1: angle loop in progress
	logic flag_q;
	logic signed [cap_pkg::ERR_W-1:0]    e_q;
	logic signed [cap_pkg::TARGET_W-1:0] setpoint_q;
	logic signed [cap_pkg::DRIVE_W-1:0]  drive_q;

	// output register
	logic out_valid_q;
	logic signed [cap_pkg::DRIVE_W-1:0] out_drive_q;
	logic out_sat_q;

	// handshake / control
	logic accept;
	logic mac_start;
	logic mac_done;
	logic out_free;
	logic out_load;
	logic signed [cap_pkg::ACC_W-1:0] mac_acc;

	// ---- configuration writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_p_q <= '0;
			angle_i_q <= '0;
			angle_d_q <= '0;
			speed_p_q <= '0;
			speed_i_q <= '0;
			speed_d_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cap_pkg::REG_ANGLE_P: angle_p_q <= cfg_data;
				cap_pkg::REG_ANGLE_I: angle_i_q <= cfg_data;
				cap_pkg::REG_ANGLE_D: angle_d_q <= cfg_data;
				cap_pkg::REG_SPEED_P: speed_p_q <= cfg_data;
				cap_pkg::REG_SPEED_I: speed_i_q <= cfg_data;
				cap_pkg::REG_SPEED_D: speed_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- error stage ----
	logic signed [cap_pkg::TARGET_W-1:0] target_sel;
	logic signed [cap_pkg::MEAS_W-1:0]   meas_sel;
	logic signed [DIFF_W-1:0] diff;
	logic diff_fits;
	logic signed [cap_pkg::ERR_W-1:0] e_next;

	always_comb begin
		if (loop_q) begin
			target_sel = angle_target_q;
			meas_sel   = angle_meas_q;
		end else begin
			target_sel = action_q ? setpoint_q : speed_target_q;
			meas_sel   = speed_meas_q;
		end
		diff = DIFF_W'(target_sel) - (DIFF_W'(meas_sel) <<< FRACTION_BITS);
		// fits when all bits above the error sign match it
		diff_fits = (diff[DIFF_W-1:cap_pkg::ERR_W-1] ==
		             {(DIFF_W-cap_pkg::ERR_W+1){diff[cap_pkg::ERR_W-1]}});
		if (diff_fits) begin
			e_next = diff[cap_pkg::ERR_W-1:0];
		end else if (diff[DIFF_W-1]) begin
			e_next = {1'b1, {(cap_pkg::ERR_W-1){1'b0}}};
		end else begin
			e_next = {1'b0, {(cap_pkg::ERR_W-1){1'b1}}};
		end
	end

	// ---- sum stage ----
	logic signed [cap_pkg::SUM_W-1:0]  sum_old;
	logic signed [cap_pkg::ERR_W-1:0]  last_old;
	logic signed [cap_pkg::SUM_W:0]    sum_total;
	logic signed [cap_pkg::SUM_W-1:0]  sum_next;
	logic sum_ovf;
	logic signed [cap_pkg::DERR_W-1:0] de;

	always_comb begin
		sum_old   = loop_q ? angle_sum_q  : speed_sum_q;
		last_old  = loop_q ? angle_last_q : speed_last_q;
		sum_total = (cap_pkg::SUM_W+1)'(sum_old) + (cap_pkg::SUM_W+1)'(e_q);
		sum_ovf   = sum_total[cap_pkg::SUM_W] != sum_total[cap_pkg::SUM_W-1];
		if (!sum_ovf) begin
			sum_next = sum_total[cap_pkg::SUM_W-1:0];
		end else if (sum_total[cap_pkg::SUM_W]) begin
			sum_next = {1'b1, {(cap_pkg::SUM_W-1){1'b0}}};
		end else begin
			sum_next = {1'b0, {(cap_pkg::SUM_W-1){1'b1}}};
		end
		de = cap_pkg::DERR_W'(e_q) - cap_pkg::DERR_W'(last_old);
	end

	// ---- bit-serial MAC, shared by both loops ----
	cap_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.kp     (loop_q ? angle_p_q : speed_p_q),
		.ki     (loop_q ? angle_i_q : speed_i_q),
		.kd     (loop_q ? angle_d_q : speed_d_q),
		.op_e   (e_q),
		.op_sum (sum_next),
		.op_de  (de),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	// ---- round and clamp ----
	logic signed [cap_pkg::ACC_W-1:0] acc_rnd;
	logic signed [cap_pkg::RND_W-1:0] rnd;
	logic sp_fits;
	logic dr_fits;
	logic signed [cap_pkg::TARGET_W-1:0] sp_next;
	logic signed [cap_pkg::DRIVE_W-1:0]  dr_next;

	always_comb begin
		acc_rnd = mac_acc + (cap_pkg::ACC_W'(1) <<< (cap_pkg::GAIN_FRAC - 1));
		rnd     = acc_rnd[cap_pkg::ACC_W-1:cap_pkg::GAIN_FRAC];
		sp_fits = (rnd[cap_pkg::RND_W-1:cap_pkg::TARGET_W-1] ==
		           {(cap_pkg::RND_W-cap_pkg::TARGET_W+1){rnd[cap_pkg::TARGET_W-1]}});
		dr_fits = (rnd[cap_pkg::RND_W-1:cap_pkg::DRIVE_W-1] ==
		           {(cap_pkg::RND_W-cap_pkg::DRIVE_W+1){rnd[cap_pkg::DRIVE_W-1]}});
		if (sp_fits) begin
			sp_next = rnd[cap_pkg::TARGET_W-1:0];
		end else if (rnd[cap_pkg::RND_W-1]) begin
			sp_next = {1'b1, {(cap_pkg::TARGET_W-1){1'b0}}};
		end else begin
			sp_next = {1'b0, {(cap_pkg::TARGET_W-1){1'b1}}};
		end
		if (dr_fits) begin
			dr_next = rnd[cap_pkg::DRIVE_W-1:0];
		end else if (rnd[cap_pkg::RND_W-1]) begin
			dr_next = {1'b1, {(cap_pkg::DRIVE_W-1){1'b0}}};
		end else begin
			dr_next = {1'b0, {(cap_pkg::DRIVE_W-1){1'b1}}};
		end
	end

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			cap_pkg::ST_IDLE: begin
				if (sample.valid) state_d = cap_pkg::ST_ERR;
			end
			cap_pkg::ST_ERR:  state_d = cap_pkg::ST_SUM;
			cap_pkg::ST_SUM:  state_d = cap_pkg::ST_MAC;
			cap_pkg::ST_MAC: begin
				if (mac_done) state_d = cap_pkg::ST_POST;
			end
			cap_pkg::ST_POST: begin
				// angle loop done: go run the speed loop on its output
				state_d = loop_q ? cap_pkg::ST_ERR : cap_pkg::ST_OUT;
			end
			cap_pkg::ST_OUT: begin
				if (out_free) state_d = cap_pkg::ST_IDLE;
			end
			default: state_d = cap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		out_free     = !out_valid_q || result.ready;
		sample.ready = (state_q == cap_pkg::ST_IDLE);
		mac_start    = (state_q == cap_pkg::ST_SUM);
		out_load     = (state_q == cap_pkg::ST_OUT) && out_free;
	end

	assign accept = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cap_pkg::ST_IDLE;
			loop_q       <= 1'b0;
			flag_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			angle_sum_q  <= '0;
			angle_last_q <= '0;
			speed_sum_q  <= '0;
			speed_last_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				loop_q <= sample.action;
				flag_q <= 1'b0;
			end
			if (state_q == cap_pkg::ST_ERR && !diff_fits) begin
				flag_q <= 1'b1;
			end
			if (state_q == cap_pkg::ST_SUM) begin
				if (sum_ovf) flag_q <= 1'b1;
				if (loop_q) begin
					angle_sum_q  <= sum_next;
					angle_last_q <= e_q;
				end else begin
					speed_sum_q  <= sum_next;
					speed_last_q <= e_q;
				end
			end
			if (state_q == cap_pkg::ST_POST) begin
				if (loop_q) begin
					loop_q <= 1'b0;
					if (!sp_fits) flag_q <= 1'b1;
				end else if (!dr_fits) begin
					flag_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q       <= sample.action;
			angle_target_q <= sample.angle_target;
			angle_meas_q   <= sample.angle_measured;
			speed_target_q <= sample.speed_target;
			speed_meas_q   <= sample.speed_measured;
		end
		if (state_q == cap_pkg::ST_ERR) begin
			e_q <= e_next;
		end
		if (state_q == cap_pkg::ST_POST) begin
			if (loop_q) begin
				setpoint_q <= sp_next;
			end else begin
				drive_q <= dr_next;
			end
		end
		if (out_load) begin
			out_drive_q <= drive_q;
			out_sat_q   <= flag_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.drive     = out_drive_q;
	assign result.saturated = out_sat_q;

endmodule
`default_nettype wire

// File: rtl/cap_mac.sv
`default_nettype none
// Bit-serial triple MAC: kp*e + ki*sum + kd*de, one gain bit per cycle, MSB first.
module cap_mac (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [cap_pkg::GAIN_W-1:0] kp,
	input  wire logic signed [cap_pkg::GAIN_W-1:0] ki,
	input  wire logic signed [cap_pkg::GAIN_W-1:0] kd,
	input  wire logic signed [cap_pkg::ERR_W-1:0]  op_e,
	input  wire logic signed [cap_pkg::SUM_W-1:0]  op_sum,
	input  wire logic signed [cap_pkg::DERR_W-1:0] op_de,
	output logic done,
	output logic signed [cap_pkg::ACC_W-1:0] acc
);

	logic [cap_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic signed [cap_pkg::ERR_W-1:0]  e_q;
	logic signed [cap_pkg::SUM_W-1:0]  sum_q;
	logic signed [cap_pkg::DERR_W-1:0] de_q;
	logic signed [cap_pkg::ACC_W-1:0]  acc_q;
	logic signed [cap_pkg::ACC_W-1:0]  pp;
	logic signed [cap_pkg::ACC_W-1:0]  acc_next;
	logic [cap_pkg::CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic first;

	assign first = (cnt_q == '0);

	always_comb begin
		pp = '0;
		if (kp_q[cap_pkg::GAIN_W-1]) begin
			pp = pp + cap_pkg::ACC_W'(e_q);
		end
		if (ki_q[cap_pkg::GAIN_W-1]) begin
			pp = pp + cap_pkg::ACC_W'(sum_q);
		end
		if (kd_q[cap_pkg::GAIN_W-1]) begin
			pp = pp + cap_pkg::ACC_W'(de_q);
		end
		// gain MSB carries negative weight
		if (first) begin
			acc_next = -pp;
		end else begin
			acc_next = (acc_q <<< 1) + pp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == cap_pkg::CNT_W'(cap_pkg::GAIN_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kp_q  <= kp;
			ki_q  <= ki;
			kd_q  <= kd;
			e_q   <= op_e;
			sum_q <= op_sum;
			de_q  <= op_de;
		end else if (run_q) begin
			kp_q  <= {kp_q[cap_pkg::GAIN_W-2:0], 1'b0};
			ki_q  <= {ki_q[cap_pkg::GAIN_W-2:0], 1'b0};
			kd_q  <= {kd_q[cap_pkg::GAIN_W-2:0], 1'b0};
			acc_q <= acc_next;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule
`default_nettype wire
